// ===== rtl/core/bipartite_graph_check_macros.svh =====
// Assertion macros shared by the bipartite graph check RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef BIPARTITE_GRAPH_CHECK_MACROS_SVH
`define BIPARTITE_GRAPH_CHECK_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define BGC_ASSERT_NOW(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define BGC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BGC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bgc_pkg.sv =====
// Package for the bipartite graph check: command and color codes, microcode types
// and the control store. No dependencies.
package bgc_pkg;

    // Command codes on the func field
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;

    // Vertex colors
    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_RED  = 2'd1;
    localparam logic [1:0] COLOR_BLUE = 2'd2;

    typedef logic [4:0] step_t;

    // Microprogram step addresses
    localparam step_t ST_CLR_ADJ    = 5'd0;
    localparam step_t ST_IDLE       = 5'd1;
    localparam step_t ST_DECODE     = 5'd2;
    localparam step_t ST_DEC_RUN    = 5'd3;
    localparam step_t ST_ADD_CHK    = 5'd4;
    localparam step_t ST_ADD_RD     = 5'd5;
    localparam step_t ST_ADD_WR     = 5'd6;
    localparam step_t ST_CLR_COL    = 5'd7;
    localparam step_t ST_START_CHK  = 5'd8;
    localparam step_t ST_START_COL  = 5'd9;
    localparam step_t ST_PUSH_START = 5'd10;
    localparam step_t ST_TOP        = 5'd11;
    localparam step_t ST_LOAD_TOP   = 5'd12;
    localparam step_t ST_LOAD_ROW   = 5'd13;
    localparam step_t ST_SCAN       = 5'd14;
    localparam step_t ST_END_CHK    = 5'd15;
    localparam step_t ST_FOUND      = 5'd16;
    localparam step_t ST_COL_CHK    = 5'd17;
    localparam step_t ST_CONFLICT   = 5'd18;
    localparam step_t ST_FAIL       = 5'd19;
    localparam step_t ST_DESCEND    = 5'd20;
    localparam step_t ST_POP        = 5'd21;
    localparam step_t ST_NEXT_START = 5'd22;
    localparam step_t ST_FINISH     = 5'd23;
    localparam step_t ST_DONE       = 5'd24;

    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_ADJ_CLR,
        UOP_LATCH,
        UOP_ADJ_RD_FROM,
        UOP_ADJ_SET,
        UOP_COL_CLR,
        UOP_COL_RD_START,
        UOP_PUSH_START,
        UOP_STK_RD,
        UOP_LOAD_TOP,
        UOP_LOAD_ROW,
        UOP_SCAN,
        UOP_FOUND,
        UOP_FAIL,
        UOP_DESCEND,
        UOP_POP,
        UOP_START_INC,
        UOP_RESULT
    } uop_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_SWEEP_MORE,
        COND_NO_TXN,
        COND_FUNC_CLEAR,
        COND_FUNC_RUN,
        COND_ADD_SKIP,
        COND_START_DONE,
        COND_COLORED,
        COND_DEPTH_ZERO,
        COND_SCAN_MISS,
        COND_C_END,
        COND_COL_NONE,
        COND_COL_DIFF,
        COND_OUT_BUSY
    } cond_t;

    // One control word: datapath operation, jump condition, jump target.
    // Next step is the target when the condition holds, else the step after.
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{op: UOP_NOP, cond: COND_ALWAYS, target: ST_IDLE};
        unique case (step)
            ST_CLR_ADJ:    w = '{op: UOP_ADJ_CLR,      cond: COND_SWEEP_MORE, target: ST_CLR_ADJ};
            ST_IDLE:       w = '{op: UOP_LATCH,        cond: COND_NO_TXN,     target: ST_IDLE};
            ST_DECODE:     w = '{op: UOP_NOP,          cond: COND_FUNC_CLEAR, target: ST_CLR_ADJ};
            ST_DEC_RUN:    w = '{op: UOP_NOP,          cond: COND_FUNC_RUN,   target: ST_CLR_COL};
            ST_ADD_CHK:    w = '{op: UOP_NOP,          cond: COND_ADD_SKIP,   target: ST_IDLE};
            ST_ADD_RD:     w = '{op: UOP_ADJ_RD_FROM,  cond: COND_NONE,       target: ST_IDLE};
            ST_ADD_WR:     w = '{op: UOP_ADJ_SET,      cond: COND_ALWAYS,     target: ST_IDLE};
            ST_CLR_COL:    w = '{op: UOP_COL_CLR,      cond: COND_SWEEP_MORE, target: ST_CLR_COL};
            ST_START_CHK:  w = '{op: UOP_COL_RD_START, cond: COND_START_DONE, target: ST_FINISH};
            ST_START_COL:  w = '{op: UOP_NOP,          cond: COND_COLORED,    target: ST_NEXT_START};
            ST_PUSH_START: w = '{op: UOP_PUSH_START,   cond: COND_NONE,       target: ST_IDLE};
            ST_TOP:        w = '{op: UOP_STK_RD,       cond: COND_DEPTH_ZERO, target: ST_NEXT_START};
            ST_LOAD_TOP:   w = '{op: UOP_LOAD_TOP,     cond: COND_NONE,       target: ST_IDLE};
            ST_LOAD_ROW:   w = '{op: UOP_LOAD_ROW,     cond: COND_NONE,       target: ST_IDLE};
            ST_SCAN:       w = '{op: UOP_SCAN,         cond: COND_SCAN_MISS,  target: ST_SCAN};
            ST_END_CHK:    w = '{op: UOP_NOP,          cond: COND_C_END,      target: ST_POP};
            ST_FOUND:      w = '{op: UOP_FOUND,        cond: COND_NONE,       target: ST_IDLE};
            ST_COL_CHK:    w = '{op: UOP_NOP,          cond: COND_COL_NONE,   target: ST_DESCEND};
            ST_CONFLICT:   w = '{op: UOP_NOP,          cond: COND_COL_DIFF,   target: ST_SCAN};
            ST_FAIL:       w = '{op: UOP_FAIL,         cond: COND_ALWAYS,     target: ST_FINISH};
            ST_DESCEND:    w = '{op: UOP_DESCEND,      cond: COND_ALWAYS,     target: ST_TOP};
            ST_POP:        w = '{op: UOP_POP,          cond: COND_ALWAYS,     target: ST_TOP};
            ST_NEXT_START: w = '{op: UOP_START_INC,    cond: COND_ALWAYS,     target: ST_START_CHK};
            ST_FINISH:     w = '{op: UOP_RESULT,       cond: COND_OUT_BUSY,   target: ST_FINISH};
            ST_DONE:       w = '{op: UOP_NOP,          cond: COND_ALWAYS,     target: ST_IDLE};
            default:       w = '{op: UOP_NOP,          cond: COND_ALWAYS,     target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/bipartite_graph_check.sv =====
// Bipartite graph check top level: microcoded sequencer, adjacency, color and stack RAMs.
// Depends on bgc_pkg and bipartite_graph_check_macros.svh.
// Usage:
//   Input channel (in_valid/in_ready) carries func, from_vertex, to_vertex.
//   func clear empties the adjacency store, add sets one edge bit (edges naming a
//   vertex at or above the vertex count are dropped), run two-colors the graph by
//   depth-first search and returns one transaction on the output channel
//   (out_valid/out_ready) with is_bipartite. Clear, add and the unused code return
//   nothing. cfg_we writes vertex_count from cfg_wdata; write it only while idle.
// Timing:
//   One transaction at a time; in_ready is high only in the idle step. A run wipes
//   the color RAM, then walks the start vertices in order, loads each stack top and
//   scans its adjacency row one bit per cycle, descending on each uncolored neighbor
//   and popping at the row's end; a same-colored neighbor ends the run early.
// Reset:
//   rst_n clears control state, sets vertex_count to 64 and starts a clearing
//   pass over all MAX_VERTICES rows of the adjacency RAM; in_ready stays low meanwhile.
// Stalls:
//   The result sits in an output register; clear and add transactions are taken
//   while it waits, and a following run holds in its last step until it drains.
`include "bipartite_graph_check_macros.svh"

module bipartite_graph_check #(
    parameter int MAX_VERTICES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [5:0] from_vertex,
    input  logic [5:0] to_vertex,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_bipartite
);
    import bgc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_VERTICES);

    // Sequencer and control state
    step_t           pc_reg, pc_next;
    logic [VW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   depth_reg, depth_next;
    logic            out_valid_reg, out_valid_next;
    logic [6:0]      vertex_count_reg;

    // Datapath registers
    logic [1:0]              func_reg, func_next;
    logic [5:0]              from_reg, from_next;
    logic [5:0]              to_reg, to_next;
    logic [CW-1:0]           start_reg, start_next;
    logic [VW-1:0]           v_reg, v_next;
    logic [CW-1:0]           c_reg, c_next;
    logic [VW-1:0]           w_reg, w_next;
    logic [1:0]              vc_reg, vc_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic                    ans_reg, ans_next;
    logic                    is_bip_reg, is_bip_next;

    // Memories and their ports
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [1:0]              col_mem [MAX_VERTICES];
    logic [VW-1:0]           stk_v_mem [MAX_VERTICES];
    logic [CW-1:0]           stk_c_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] adj_rd_reg;
    logic [1:0]              col_rd_reg;
    logic [VW-1:0]           stk_v_rd_reg;
    logic [CW-1:0]           stk_c_rd_reg;

    logic                    adj_we, adj_re;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic                    col_we, col_re;
    logic [VW-1:0]           col_waddr, col_raddr;
    logic [1:0]              col_wdata;
    logic                    stk_v_we, stk_c_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr;
    logic [VW-1:0]           stk_v_wdata;
    logic [CW-1:0]           stk_c_wdata;

    ucode_t          uw;
    logic            cond_true;
    logic [CW-1:0]   n_act;
    logic [CW-1:0]   depth_m1;
    logic            scan_miss;
    logic            out_busy;
    logic            add_skip;

    // Active vertex count, saturated at the store size
    always_comb
    begin
        if (32'(vertex_count_reg) > MAX_VERTICES)
        begin
            n_act = MAX_CNT;
        end
        else
        begin
            n_act = CW'(vertex_count_reg);
        end
    end

    assign uw        = ucode_rom(pc_reg);
    assign depth_m1  = depth_reg - CW'(1);
    assign scan_miss = (c_reg < n_act) && !row_reg[c_reg[VW-1:0]];
    assign out_busy  = out_valid_reg && !out_ready;
    assign add_skip  = (func_reg != FUNC_ADD) || (32'(from_reg) >= 32'(n_act))
                       || (32'(to_reg) >= 32'(n_act));

    assign in_ready     = (pc_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign is_bipartite = is_bip_reg;

    // Jump condition select
    always_comb
    begin
        unique case (uw.cond)
            COND_NONE:       cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_SWEEP_MORE: cond_true = (ptr_reg != LAST_IDX);
            COND_NO_TXN:     cond_true = !in_valid;
            COND_FUNC_CLEAR: cond_true = (func_reg == FUNC_CLEAR);
            COND_FUNC_RUN:   cond_true = (func_reg == FUNC_RUN);
            COND_ADD_SKIP:   cond_true = add_skip;
            COND_START_DONE: cond_true = (start_reg >= n_act);
            COND_COLORED:    cond_true = (col_rd_reg != COLOR_NONE);
            COND_DEPTH_ZERO: cond_true = (depth_reg == '0);
            COND_SCAN_MISS:  cond_true = scan_miss;
            COND_C_END:      cond_true = (c_reg >= n_act);
            COND_COL_NONE:   cond_true = (col_rd_reg == COLOR_NONE);
            COND_COL_DIFF:   cond_true = (col_rd_reg != vc_reg);
            COND_OUT_BUSY:   cond_true = out_busy;
            default:         cond_true = 1'b1;
        endcase
        pc_next = cond_true ? uw.target : step_t'(pc_reg + 1'b1);
    end

    // Datapath: one operation per control word
    always_comb
    begin
        ptr_next       = ptr_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && !out_ready;
        func_next      = func_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        start_next     = start_reg;
        v_next         = v_reg;
        c_next         = c_reg;
        w_next         = w_reg;
        vc_next        = vc_reg;
        row_next       = row_reg;
        ans_next       = ans_reg;
        is_bip_next    = is_bip_reg;

        adj_we      = 1'b0;
        adj_waddr   = ptr_reg;
        adj_wdata   = '0;
        adj_re      = 1'b0;
        adj_raddr   = VW'(from_reg);
        col_we      = 1'b0;
        col_waddr   = ptr_reg;
        col_wdata   = COLOR_NONE;
        col_re      = 1'b0;
        col_raddr   = start_reg[VW-1:0];
        stk_v_we    = 1'b0;
        stk_c_we    = 1'b0;
        stk_waddr   = depth_m1[VW-1:0];
        stk_v_wdata = w_reg;
        stk_c_wdata = '0;
        stk_re      = 1'b0;
        stk_raddr   = depth_m1[VW-1:0];

        unique case (uw.op)
            UOP_NOP:
            begin
            end
            UOP_ADJ_CLR:
            begin
                adj_we   = 1'b1;
                ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + VW'(1);
            end
            UOP_LATCH:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    from_next = from_vertex;
                    to_next   = to_vertex;
                end
            end
            UOP_ADJ_RD_FROM:
            begin
                adj_re = 1'b1;
            end
            UOP_ADJ_SET:
            begin
                adj_we    = 1'b1;
                adj_waddr = VW'(from_reg);
                adj_wdata = adj_rd_reg | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << to_reg);
            end
            UOP_COL_CLR:
            begin
                col_we     = 1'b1;
                ptr_next   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + VW'(1);
                start_next = '0;
                ans_next   = 1'b1;
            end
            UOP_COL_RD_START:
            begin
                col_re = 1'b1;
            end
            UOP_PUSH_START:
            begin
                // Color the root red and make it the only stack entry
                col_we      = 1'b1;
                col_waddr   = start_reg[VW-1:0];
                col_wdata   = COLOR_RED;
                stk_v_we    = 1'b1;
                stk_c_we    = 1'b1;
                stk_waddr   = '0;
                stk_v_wdata = start_reg[VW-1:0];
                stk_c_wdata = '0;
                depth_next  = CW'(1);
            end
            UOP_STK_RD:
            begin
                stk_re = 1'b1;
            end
            UOP_LOAD_TOP:
            begin
                v_next    = stk_v_rd_reg;
                c_next    = stk_c_rd_reg;
                adj_re    = 1'b1;
                adj_raddr = stk_v_rd_reg;
                col_re    = 1'b1;
                col_raddr = stk_v_rd_reg;
            end
            UOP_LOAD_ROW:
            begin
                row_next = adj_rd_reg;
                vc_next  = col_rd_reg;
            end
            UOP_SCAN:
            begin
                if (scan_miss)
                begin
                    c_next = c_reg + CW'(1);
                end
            end
            UOP_FOUND:
            begin
                // Save the resume point and fetch the neighbor's color
                w_next      = c_reg[VW-1:0];
                c_next      = c_reg + CW'(1);
                stk_c_we    = 1'b1;
                stk_c_wdata = c_reg + CW'(1);
                col_re      = 1'b1;
                col_raddr   = c_reg[VW-1:0];
            end
            UOP_FAIL:
            begin
                ans_next   = 1'b0;
                depth_next = '0;
            end
            UOP_DESCEND:
            begin
                col_we    = 1'b1;
                col_waddr = w_reg;
                col_wdata = (vc_reg == COLOR_RED) ? COLOR_BLUE : COLOR_RED;
                if (depth_reg < MAX_CNT)
                begin
                    stk_v_we    = 1'b1;
                    stk_c_we    = 1'b1;
                    stk_waddr   = depth_reg[VW-1:0];
                    stk_v_wdata = w_reg;
                    stk_c_wdata = '0;
                    depth_next  = depth_reg + CW'(1);
                end
            end
            UOP_POP:
            begin
                depth_next = depth_m1;
            end
            UOP_START_INC:
            begin
                start_next = start_reg + CW'(1);
            end
            UOP_RESULT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    is_bip_next    = ans_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= ST_CLR_ADJ;
            ptr_reg          <= '0;
            depth_reg        <= '0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= 7'd64;
        end
        else
        begin
            pc_reg        <= pc_next;
            ptr_reg       <= ptr_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        from_reg   <= from_next;
        to_reg     <= to_next;
        start_reg  <= start_next;
        v_reg      <= v_next;
        c_reg      <= c_next;
        w_reg      <= w_next;
        vc_reg     <= vc_next;
        row_reg    <= row_next;
        ans_reg    <= ans_next;
        is_bip_reg <= is_bip_next;
    end

    // Adjacency RAM
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd_reg <= adj_mem[adj_raddr];
        end
    end

    // Color RAM
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_rd_reg <= col_mem[col_raddr];
        end
    end

    // Walk stack RAMs
    always_ff @(posedge clk)
    begin
        if (stk_v_we)
        begin
            stk_v_mem[stk_waddr] <= stk_v_wdata;
        end
        if (stk_c_we)
        begin
            stk_c_mem[stk_waddr] <= stk_c_wdata;
        end
        if (stk_re)
        begin
            stk_v_rd_reg <= stk_v_mem[stk_raddr];
            stk_c_rd_reg <= stk_c_mem[stk_raddr];
        end
    end

    // A walk always unwinds before the block goes idle
    `BGC_ASSERT_IMP(a_idle_stack_empty, in_ready, depth_reg == '0, "stack not empty while idle")
    // Stack never grows past the store
    `BGC_ASSERT_NOW(a_depth_bound, depth_reg <= MAX_CNT, "stack depth beyond vertex store")
    // The conflict test only sees neighbors that are already colored
    `BGC_ASSERT_IMP(a_conflict_colored, pc_reg == ST_CONFLICT, col_rd_reg != COLOR_NONE, "conflict test on uncolored vertex")
    // A run result enters the output register as soon as it is free
    `BGC_ASSERT_NXT(a_result_loaded, (pc_reg == ST_FINISH) && !out_busy, out_valid_reg, "run result not presented")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for bipartite_graph_check: a directed script, then random
// graph-building phases. Depends on bgc_pkg and the bipartite_graph_check RTL.
module tb_top;
    import bgc_pkg::*;

    localparam int MAX_V = 64;
    localparam int ITEM_GOAL = 1550;
    localparam int QUIET_TAIL = 150;            // last items run with no idling
    localparam int SETTLE = MAX_V + 16;         // outlasts a clear's sweep of all MAX_V rows
    localparam int WATCHDOG_LIMIT = 200000;     // cycles without any transaction
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = FUNC_CLEAR;
    logic [5:0] from_vertex = '0;
    logic [5:0] to_vertex = '0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic       is_bipartite;

    bipartite_graph_check #(.MAX_VERTICES(MAX_V)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .from_vertex(from_vertex),
        .to_vertex(to_vertex),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_bipartite(is_bipartite)
    );

    // Shadow of the block: edge rows, the vertex count register, pending verdicts
    bit [MAX_V-1:0] edge_map [MAX_V];
    logic [6:0]     count_shadow = 7'd64;
    bit             verdict_q [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  items_sent = 0;
    bit  quiet_tail = 1'b0;
    bit  want_verdict;

    // One line of the directed script: either a vertex count write or a transaction.
    // A typed row carries its verdict; the rest go through the predictor.
    typedef struct packed {
        bit         set_count;
        logic [1:0] fn;
        logic [5:0] src;
        logic [5:0] dst;
        logic [6:0] count;
        bit         typed;
        bit         want;
    } script_row_t;

    script_row_t script [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int vertices_in_use();
        return (count_shadow > MAX_V) ? MAX_V : int'(count_shadow);
    endfunction

    // Two-color the shadow graph by depth-first search: starts in ascending order,
    // out-neighbors in ascending order, edges past the count skipped.
    function automatic bit two_colorable();
        logic [1:0] shade [MAX_V];
        int         path_v [MAX_V];
        int         path_next [MAX_V];
        int         n;
        int         depth;
        int         top;
        int         v;
        int         c;
        n = vertices_in_use();
        for (int i = 0; i < MAX_V; i++)
            shade[i] = COLOR_NONE;
        for (int s = 0; s < n; s++)
        begin
            if (shade[s] != COLOR_NONE)
                continue;
            shade[s] = COLOR_RED;
            path_v[0] = s;
            path_next[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                top = depth - 1;
                v = path_v[top];
                c = path_next[top];
                while (c < n && !edge_map[v][c])
                    c++;
                if (c >= n)
                begin
                    depth = top;
                    continue;
                end
                path_next[top] = c + 1;
                if (shade[c] == COLOR_NONE)
                begin
                    shade[c] = (shade[v] == COLOR_RED) ? COLOR_BLUE : COLOR_RED;
                    if (depth < MAX_V)
                    begin
                        path_v[depth] = c;
                        path_next[depth] = 0;
                        depth++;
                    end
                end
                else if (shade[c] == shade[v])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Drive one transaction and hold it until accepted; leave valid high so a
    // back-to-back transaction needs no second assignment in the same step.
    task automatic send_item(input logic [1:0] fn, input logic [5:0] src,
                             input logic [5:0] dst, input bit typed, input bit want);
        int n;
        n = vertices_in_use();
        in_valid <= 1'b1;
        func <= fn;
        from_vertex <= src;
        to_vertex <= dst;
        do @(posedge clk); while (in_ready !== 1'b1);
        items_sent++;
        case (fn)
            FUNC_CLEAR:
            begin
                foreach (edge_map[i])
                    edge_map[i] = '0;
            end
            FUNC_ADD:
            begin
                if (src < n && dst < n)
                    edge_map[src][dst] = 1'b1;
            end
            FUNC_RUN:
            begin
                verdict_q.push_back(typed ? want : two_colorable());
            end
            default: ;
        endcase
    endtask

    // Occasionally drop valid for a while, outside the quiet tail.
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Hold off until every verdict is back, then let a trailing clear or add finish.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [6:0] value);
        settle_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        count_shadow = value;
    endtask

    function automatic void row_item(input logic [1:0] fn, input logic [5:0] src,
                                     input logic [5:0] dst, input bit typed, input bit want);
        script.push_back('{set_count: 1'b0, fn: fn, src: src, dst: dst, count: '0,
                           typed: typed, want: want});
    endfunction

    function automatic void row_count(input logic [6:0] value);
        script.push_back('{set_count: 1'b1, fn: FUNC_CLEAR, src: '0, dst: '0, count: value,
                           typed: 1'b0, want: 1'b0});
    endfunction

    // Result monitor: compare each accepted result with the oldest pending verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
                report($sformatf("is_bipartite=%b with no run pending", is_bipartite));
            else
            begin
                want_verdict = verdict_q.pop_front();
                if (is_bipartite !== want_verdict)
                    report($sformatf("is_bipartite=%b, want %b", is_bipartite, want_verdict));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall in random bursts, never once the tail of the run is reached.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        int          n;
        int          phase_len;
        int          bad_pct;
        int          pick;
        int          tries;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [6:0]  next_count;
        bit [MAX_V-1:0] side;

        foreach (edge_map[i])
            edge_map[i] = '0;

        // Empty graph after reset, self-loop, clear, top corner, unused code
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);
        row_item(FUNC_ADD, 6'd0, 6'd0, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b0);
        row_item(FUNC_CLEAR, 6'd63, 6'd63, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd63, 6'd63, 1'b1, 1'b1);
        row_item(FUNC_ADD, 6'd63, 6'd62, 1'b0, 1'b0);
        row_item(FUNC_ADD, 6'd62, 6'd63, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);
        row_item(FUNC_UNUSED, 6'd63, 6'd63, 1'b0, 1'b0);
        // No vertices at all: always two-colorable, adds dropped
        row_count(7'd0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);
        row_item(FUNC_ADD, 6'd0, 6'd0, 1'b0, 1'b0);
        // Single vertex, then its self-loop
        row_count(7'd1);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);
        row_item(FUNC_ADD, 6'd0, 6'd0, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b0);
        // Count above the maximum saturates
        row_count(7'd127);
        row_item(FUNC_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0);
        row_item(FUNC_ADD, 6'd0, 6'd63, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);
        row_item(FUNC_ADD, 6'd63, 6'd63, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b0);
        // Odd cycle through vertex 40; shrinking the count hides it
        row_item(FUNC_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0);
        row_item(FUNC_ADD, 6'd0, 6'd1, 1'b0, 1'b0);
        row_item(FUNC_ADD, 6'd1, 6'd40, 1'b0, 1'b0);
        row_item(FUNC_ADD, 6'd40, 6'd0, 1'b0, 1'b0);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b0);
        row_count(7'd2);
        row_item(FUNC_RUN, 6'd0, 6'd0, 1'b1, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].set_count)
                set_vertex_count(script[i].count);
            else
            begin
                sender_gap();
                send_item(script[i].fn, script[i].src, script[i].dst,
                          script[i].typed, script[i].want);
            end
        end

        // Random phases: pick a count, build a mostly two-colorable graph over a
        // hidden partition, sprinkle noise and mid-phase runs, close with a run.
        while (items_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 19))
                0:       next_count = 7'd0;
                1:       next_count = 7'd64;
                2:       next_count = 7'd127;
                3:       next_count = 7'($urandom_range(65, 126));
                4, 5:    next_count = 7'($urandom_range(17, 63));
                default: next_count = 7'($urandom_range(1, 16));
            endcase
            set_vertex_count(next_count);
            n = vertices_in_use();
            side = {$urandom, $urandom};
            bad_pct = ($urandom_range(0, 1) == 0) ? 0 : 8;
            phase_len = (n <= 16) ? $urandom_range(4, 2 * n + 4) : $urandom_range(4, 40);

            // Keep stale edges now and then so runs meet edges past the count
            if ($urandom_range(0, 3) != 0)
            begin
                sender_gap();
                send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom), 1'b0, 1'b0);
            end

            for (int k = 0; k < phase_len; k++)
            begin
                quiet_tail = (items_sent >= ITEM_GOAL - QUIET_TAIL);
                pick = $urandom_range(0, 99);
                src = 6'($urandom);
                dst = 6'($urandom);
                sender_gap();
                if (pick < 5)
                    send_item(FUNC_RUN, src, dst, 1'b0, 1'b0);
                else if (pick < 8)
                    send_item(FUNC_CLEAR, src, dst, 1'b0, 1'b0);
                else if (pick < 12)
                    send_item(FUNC_UNUSED, src, dst, 1'b0, 1'b0);
                else if (pick < 20 || n == 0)
                    send_item(FUNC_ADD, src, dst, 1'b0, 1'b0);
                else
                begin
                    src = 6'($urandom_range(0, n - 1));
                    dst = 6'($urandom_range(0, n - 1));
                    // Steer toward the other side unless this edge is meant to break it
                    if ($urandom_range(0, 99) >= bad_pct)
                    begin
                        tries = 0;
                        while (side[src] == side[dst] && tries < 4)
                        begin
                            dst = 6'($urandom_range(0, n - 1));
                            tries++;
                        end
                    end
                    send_item(FUNC_ADD, src, dst, 1'b0, 1'b0);
                end
            end
            sender_gap();
            send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 1'b0, 1'b0);
        end

        // Drain: wait out every pending verdict, then a little longer
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (verdict_q.size() != 0)
            report($sformatf("%0d verdicts never arrived", verdict_q.size()));

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
